### rtl/core/fm_index_backward_search_defines.svh
// assertion helpers
`ifndef FM_INDEX_BACKWARD_SEARCH_DEFINES_SVH
`define FM_INDEX_BACKWARD_SEARCH_DEFINES_SVH
`define FMI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("label failed");
`define FMI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("label failed");
`endif

### rtl/core/fmi_pkg.sv
package fmi_pkg;
   localparam int INDEX_DEPTH = 65536;
   localparam int IDX_W = $clog2(INDEX_DEPTH);
   localparam int MAX_HITS_OUT = 64;
   localparam int HIT_W = $clog2(MAX_HITS_OUT + 1);
   localparam int ROW_W = 17;
   localparam int LEN_W = 16;
   localparam int QDEPTH = 2;

   localparam logic [1:0] OP_LOAD_TALLY = 2'd0;
   localparam logic [1:0] OP_LOAD_SUFFIX = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [2:0] CSR_COUNT_A = 3'd0;
   localparam logic [2:0] CSR_COUNT_C = 3'd1;
   localparam logic [2:0] CSR_COUNT_G = 3'd2;
   localparam logic [2:0] CSR_COUNT_T = 3'd3;
   localparam logic [2:0] CSR_MODE = 3'd4;

   localparam logic [2:0] BASE_NONE = 3'd4;

   typedef struct packed {
      logic [1:0] op;
      logic [15:0] address;
      logic [ROW_W-1:0] tally_a_value;
      logic [ROW_W-1:0] tally_c_value;
      logic [ROW_W-1:0] tally_g_value;
      logic [ROW_W-1:0] tally_t_value;
      logic [15:0] suffix_value;
      logic [7:0] symbol;
      logic final_symbol;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] match_len;
      logic [ROW_W-1:0] hit_count;
      logic [15:0] location;
      logic location_valid;
      logic truncated;
      logic last;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0] op;
      logic [IDX_W-1:0] address;
      logic [ROW_W-1:0] tally_a_value;
      logic [ROW_W-1:0] tally_c_value;
      logic [ROW_W-1:0] tally_g_value;
      logic [ROW_W-1:0] tally_t_value;
      logic [15:0] suffix_value;
      logic [2:0] base;
      logic final_symbol;
   } cmd_type;

   function automatic logic [2:0] base_code(input logic [7:0] s);
      case (s)
         8'h61, 8'h41: base_code = 3'd0;
         8'h63, 8'h43: base_code = 3'd1;
         8'h67, 8'h47: base_code = 3'd2;
         8'h74, 8'h54: base_code = 3'd3;
         default: base_code = BASE_NONE;
      endcase
   endfunction
endpackage

### rtl/core/fmi_if.sv
interface fmi_req_if;
   logic valid;
   logic ready;
   fmi_pkg::req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface fmi_rsp_if;
   logic valid;
   logic ready;
   fmi_pkg::rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

### rtl/core/fmi_front.sv
module fmi_front (
   input logic clock,
   input logic reset,
   fmi_req_if.sink req,
   output logic cmd_valid,
   output fmi_pkg::cmd_type cmd,
   input logic cmd_pop
);
   fmi_pkg::cmd_type q_ff [fmi_pkg::QDEPTH];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;
   fmi_pkg::cmd_type c;

   always_comb begin
      c.op = req.payload.op;
      c.address = req.payload.address[fmi_pkg::IDX_W-1:0];
      c.tally_a_value = req.payload.tally_a_value;
      c.tally_c_value = req.payload.tally_c_value;
      c.tally_g_value = req.payload.tally_g_value;
      c.tally_t_value = req.payload.tally_t_value;
      c.suffix_value = req.payload.suffix_value;
      c.base = fmi_pkg::base_code(req.payload.symbol);
      c.final_symbol = req.payload.final_symbol;
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready && (req.payload.op != fmi_pkg::OP_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rp_ff];
   assign wp_in = push ? ~wp_ff : wp_ff;
   assign rp_in = cmd_pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= c;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/core/fmi_back.sv
module fmi_back (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   input fmi_pkg::cmd_type cmd,
   output logic cmd_pop,
   input logic [fmi_pkg::ROW_W-1:0] count_a,
   input logic [fmi_pkg::ROW_W-1:0] count_c,
   input logic [fmi_pkg::ROW_W-1:0] count_g,
   input logic [fmi_pkg::ROW_W-1:0] count_t,
   input logic complete_mode,
   fmi_rsp_if.source rsp
);
   localparam int RW = fmi_pkg::ROW_W;
   localparam int IW = fmi_pkg::IDX_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_TALLY = 5'b00010,
      S_PREP = 5'b00100,
      S_READ = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [RW-1:0] ta_mem [fmi_pkg::INDEX_DEPTH];
   logic [RW-1:0] tc_mem [fmi_pkg::INDEX_DEPTH];
   logic [RW-1:0] tg_mem [fmi_pkg::INDEX_DEPTH];
   logic [RW-1:0] tt_mem [fmi_pkg::INDEX_DEPTH];
   logic [15:0] sa_mem [fmi_pkg::INDEX_DEPTH];

   logic [RW-1:0] lo_rd_ff [4];
   logic [RW-1:0] hi_rd_ff [4];
   logic [15:0] sa_rd_ff;

   logic [RW-1:0] start_ff, start_in, end_ff, end_in;
   logic [fmi_pkg::LEN_W-1:0] len_ff, len_in;
   logic stopped_ff, stopped_in, first_ff, first_in;
   logic [2:0] base_ff, base_in;
   logic final_ff, final_in;
   logic [RW-1:0] hits_ff, hits_in;
   logic [fmi_pkg::HIT_W-1:0] n_ff, n_in, k_ff, k_in;
   logic trunc_ff, trunc_in;
   logic [IW-1:0] row_ff, row_in;
   logic out_valid_ff, out_valid_in;
   fmi_pkg::rsp_type out_ff, out_in;

   logic [RW-1:0] bbase, bsize, lo, hi;
   logic is_tally_q, is_sfx, is_query, take;
   logic [IW-1:0] ra_lo, ra_hi;

   always_comb begin
      bbase = RW'(1);
      bsize = count_t;
      case (base_ff)
         3'd0: begin bsize = count_a; end
         3'd1: begin bbase = RW'(1) + count_a; bsize = count_c; end
         3'd2: begin bbase = RW'(1) + count_a + count_c; bsize = count_g; end
         default: begin bbase = RW'(1) + count_a + count_c + count_g; end
      endcase
      lo = lo_rd_ff[base_ff[1:0]];
      hi = hi_rd_ff[base_ff[1:0]];
   end

   assign take = cmd_valid && (state_ff == S_IDLE) && !(out_valid_ff && !rsp.ready);
   assign cmd_pop = take;
   assign is_tally_q = take && cmd.op == fmi_pkg::OP_LOAD_TALLY;
   assign is_sfx = take && cmd.op == fmi_pkg::OP_LOAD_SUFFIX;
   assign is_query = take && cmd.op == fmi_pkg::OP_QUERY;
   assign ra_lo = start_ff[IW-1:0] - IW'(1);
   assign ra_hi = end_ff[IW-1:0] - IW'(1);

   always_ff @(posedge clock) begin
      if (is_tally_q) begin
         ta_mem[cmd.address] <= cmd.tally_a_value;
         tc_mem[cmd.address] <= cmd.tally_c_value;
         tg_mem[cmd.address] <= cmd.tally_g_value;
         tt_mem[cmd.address] <= cmd.tally_t_value;
      end
      if (is_sfx) sa_mem[cmd.address] <= cmd.suffix_value;
      lo_rd_ff[0] <= ta_mem[ra_lo];
      lo_rd_ff[1] <= tc_mem[ra_lo];
      lo_rd_ff[2] <= tg_mem[ra_lo];
      lo_rd_ff[3] <= tt_mem[ra_lo];
      hi_rd_ff[0] <= ta_mem[ra_hi];
      hi_rd_ff[1] <= tc_mem[ra_hi];
      hi_rd_ff[2] <= tg_mem[ra_hi];
      hi_rd_ff[3] <= tt_mem[ra_hi];
      sa_rd_ff <= sa_mem[row_ff];
   end

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      end_in = end_ff;
      len_in = len_ff;
      stopped_in = stopped_ff;
      first_in = first_ff;
      base_in = base_ff;
      final_in = final_ff;
      hits_in = hits_ff;
      n_in = n_ff;
      k_in = k_ff;
      trunc_in = trunc_ff;
      row_in = row_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in = out_ff;
      case (state_ff)
         S_IDLE: begin
            if (is_query) begin
               base_in = cmd.base;
               final_in = cmd.final_symbol;
               state_in = S_TALLY;
            end
         end
         S_TALLY: begin
            // tally reads for start_ff/end_ff are now registered
            state_in = final_ff ? S_PREP : S_IDLE;
            if (first_ff) begin
               first_in = 1'b0;
               if (base_ff == fmi_pkg::BASE_NONE) begin
                  start_in = '0;
                  end_in = '0;
                  len_in = '0;
                  stopped_in = 1'b1;
               end else begin
                  start_in = bbase;
                  end_in = bbase + bsize;
                  len_in = fmi_pkg::LEN_W'(1);
               end
            end else if (!stopped_ff) begin
               if (base_ff == fmi_pkg::BASE_NONE || lo == hi) begin
                  stopped_in = 1'b1;
                  if (complete_mode) begin
                     start_in = '0;
                     end_in = '0;
                     len_in = '0;
                  end
               end else begin
                  start_in = lo + bbase;
                  end_in = hi + bbase;
                  if (len_ff != '1) len_in = len_ff + fmi_pkg::LEN_W'(1);
               end
            end
         end
         S_PREP: begin
            hits_in = (end_ff > start_ff) ? end_ff - start_ff : '0;
            trunc_in = hits_in > RW'(fmi_pkg::MAX_HITS_OUT);
            n_in = trunc_in ? fmi_pkg::HIT_W'(fmi_pkg::MAX_HITS_OUT)
                            : fmi_pkg::HIT_W'(hits_in);
            k_in = '0;
            row_in = start_ff[IW-1:0];
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_valid_in) begin
               out_valid_in = 1'b1;
               out_in.match_len = len_ff;
               out_in.hit_count = hits_ff;
               out_in.location = (n_ff == '0) ? 16'd0 : sa_rd_ff;
               out_in.location_valid = (n_ff != '0);
               out_in.truncated = trunc_ff;
               out_in.last = (n_ff == '0) || (k_ff + fmi_pkg::HIT_W'(1) == n_ff);
               if (out_in.last) begin
                  start_in = '0;
                  end_in = '0;
                  len_in = '0;
                  stopped_in = 1'b0;
                  first_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + fmi_pkg::HIT_W'(1);
                  row_in = row_ff + IW'(1);
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      final_ff <= final_in;
      hits_ff <= hits_in;
      n_ff <= n_in;
      k_ff <= k_in;
      trunc_ff <= trunc_in;
      row_ff <= row_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= '0;
         end_ff <= '0;
         len_ff <= '0;
         stopped_ff <= 1'b0;
         first_ff <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         end_ff <= end_in;
         len_ff <= len_in;
         stopped_ff <= stopped_in;
         first_ff <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

### rtl/core/fm_index_backward_search.sv
// FM-index backward search. A load item is written to the tally or suffix memory as
// it is taken from the queue. A query base gets a registered tally read at both range
// ends, then the range update. A final base then sizes the range in a prep state and
// emits max(1, min(hits, 64)) results, each paced by the registered suffix memory
// read; a result held by the receiver stalls the back end. A two-entry queue
// decouples input from the back end; op 3 items are dropped at the front.
`include "fm_index_backward_search_defines.svh"
module fm_index_backward_search (
   input logic clock,
   input logic reset,
   fmi_req_if.sink req,
   fmi_rsp_if.source rsp,
   input logic csr_we,
   input logic [2:0] csr_index,
   input logic [fmi_pkg::ROW_W-1:0] csr_wdata
);
   logic [fmi_pkg::ROW_W-1:0] ca_ff, cc_ff, cg_ff, ct_ff;
   logic mode_ff;
   logic cmd_valid, cmd_pop;
   fmi_pkg::cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= '0;
         cc_ff <= '0;
         cg_ff <= '0;
         ct_ff <= '0;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            fmi_pkg::CSR_COUNT_A: ca_ff <= csr_wdata;
            fmi_pkg::CSR_COUNT_C: cc_ff <= csr_wdata;
            fmi_pkg::CSR_COUNT_G: cg_ff <= csr_wdata;
            fmi_pkg::CSR_COUNT_T: ct_ff <= csr_wdata;
            fmi_pkg::CSR_MODE: mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   fmi_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
   );

   fmi_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_pop(cmd_pop), .count_a(ca_ff), .count_c(cc_ff), .count_g(cg_ff),
      .count_t(ct_ff), .complete_mode(mode_ff), .rsp(rsp)
   );

   `FMI_ASSERT_IMP(a_pop_needs_item, cmd_pop, cmd_valid)
   `FMI_ASSERT_NEXT(a_rsp_holds, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload))
   `FMI_ASSERT_IMP(a_no_loc_without_hits,
      rsp.valid && rsp.payload.location_valid, rsp.payload.hit_count != '0)
endmodule
